### design/lbvs_pkg.sv
// Shared types and constants of the linear blend vertex skinning core.
package lbvs_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_POS     = 2'd1,
        ACT_NORMAL  = 2'd2,
        ACT_TANGENT = 2'd3
    } action_t;

    localparam int CELLS     = 12;
    localparam int CELL_W    = 4;
    localparam int WORD_W    = 32;
    localparam int WEIGHT_W  = 15;
    localparam int PROD_W    = 48;
    localparam int ROW_W     = 50;
    localparam int CONTRIB_W = 52;
    localparam int ACC_W     = 54;

    typedef struct packed {
        logic              en;
        logic [7:0]        slot;
        logic [CELL_W-1:0] cell_idx;
        logic [WORD_W-1:0] word;
    } pal_wr_t;

endpackage

### design/linear_blend_vertex_skinning_core.sv
// Top level of the linear blend vertex skinning core.
//
// Usage: requests enter on the input channel (in_valid / in_stall). A load
// request (action 0) writes one Q16.16 word of a 3x4 bone matrix into the
// palette and produces no result; a skin request (positions, normals or
// tangents) produces exactly one result on the output channel
// (out_valid / out_stall) holding the blended vector and its flags.
// Throughput is one request per cycle while the output is not stalled.
// A skin request's palette read is registered at the edge that accepts
// it; then the matrix multiplies, the row sums, the weight multiply and
// the final accumulate with saturation take one stage each. The 36
// matrix-by-component multipliers and the twelve weight multipliers each
// sit in their own pipeline stage.
// A load is visible to any skin request accepted in a later cycle.
// Reset clears every valid bit of the pipeline; the palette is not
// cleared and must be loaded before a bone is used. When the receiver
// stalls a pending result, the whole pipeline holds and in_stall is raised
// in the same cycle, so nothing is lost or repeated.
module linear_blend_vertex_skinning_core #(
    parameter int BONE_COUNT     = 256,
    parameter int MAX_INFLUENCES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic signed [31:0]   comp_x,
    input  logic signed [31:0]   comp_y,
    input  logic signed [31:0]   comp_z,
    input  logic [31:0]          bone_list,
    input  logic [59:0]          weight_list,
    input  logic [7:0]           matrix_slot,
    input  logic [3:0]           matrix_cell,
    input  logic signed [31:0]   matrix_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   out_x,
    output logic signed [31:0]   out_y,
    output logic signed [31:0]   out_z,
    output logic [2:0]           bones_used,
    output logic                 skipped,
    output logic                 clipped
);
    import lbvs_pkg::*;

    localparam int BONE_AW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

    logic adv;
    logic accept;
    pal_wr_t pal_wr;
    logic [MAX_INFLUENCES-1:0][BONE_AW-1:0] raddr;
    logic [MAX_INFLUENCES-1:0][CELLS-1:0][WORD_W-1:0] mat;
    logic [MAX_INFLUENCES-1:0][2:0][CONTRIB_W-1:0] contrib;

    // Request decode.
    logic [2:0] used_next;
    logic [MAX_INFLUENCES-1:0] ok_next;
    logic alive;

    // Pipeline control and payload.
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic [2:0] used1_reg, used2_reg, used3_reg, used4_reg;
    logic [2:0][WORD_W-1:0] vec1_reg, vec2_reg, vec3_reg, vec4_reg;
    logic pos1_reg;
    logic [MAX_INFLUENCES-1:0][WEIGHT_W-1:0] w1_reg, w1_next;
    logic [MAX_INFLUENCES-1:0] ok1_reg;

    logic [2:0][ACC_W-1:0] acc;
    logic [2:0][WORD_W-1:0] sat;
    logic [2:0] clip;
    logic [2:0][WORD_W-1:0] res_reg, res_next;
    logic [2:0] used_out_reg;
    logic skipped_reg, clipped_reg, clipped_next;

    // The pipeline advances unless a finished result is held by the receiver.
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    always_comb
    begin
        pal_wr.en       = accept && (action == ACT_LOAD) && (matrix_cell < CELL_W'(CELLS))
                        && ({1'b0, matrix_slot} < 9'(BONE_COUNT));
        pal_wr.slot     = matrix_slot;
        pal_wr.cell_idx = matrix_cell;
        pal_wr.word     = matrix_word;
    end

    // Count influences up to the first zero weight; inactive lanes get weight zero.
    always_comb
    begin
        alive     = 1'b1;
        used_next = '0;
        for (int k = 0; k < MAX_INFLUENCES; k++)
        begin
            alive = alive && (weight_list[15*k +: WEIGHT_W] != '0);
            used_next = used_next + 3'(alive);
            w1_next[k] = alive ? weight_list[15*k +: WEIGHT_W] : '0;
            ok_next[k] = ({1'b0, bone_list[8*k +: 8]} < 9'(BONE_COUNT));
            raddr[k]   = bone_list[8*k +: BONE_AW];
        end
    end

    lbvs_palette #(
        .BONE_COUNT    (BONE_COUNT),
        .MAX_INFLUENCES(MAX_INFLUENCES),
        .AW            (BONE_AW)
    ) u_palette (
        .clk  (clk),
        .wr   (pal_wr),
        .re   (adv),
        .raddr(raddr),
        .rdata(mat)
    );

    for (genvar k = 0; k < MAX_INFLUENCES; k++)
    begin : g_lane
        lbvs_lane u_lane (
            .clk    (clk),
            .en     (adv),
            .is_pos (pos1_reg),
            .bone_ok(ok1_reg[k]),
            .weight (w1_reg[k]),
            .vec    (vec1_reg),
            .mat    (mat[k]),
            .contrib(contrib[k])
        );
    end

    // Sum lanes, saturating each component to 32 bits; a skip passes the vector.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = '0;
            for (int k = 0; k < MAX_INFLUENCES; k++)
            begin
                acc[r] = acc[r] + ACC_W'($signed(contrib[k][r]));
            end
            clip[r] = !((&acc[r][ACC_W-1:31]) || !(|acc[r][ACC_W-1:31]));
            sat[r]  = clip[r] ? (acc[r][ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                              : acc[r][31:0];
            res_next[r] = (used4_reg == '0) ? vec4_reg[r] : sat[r];
        end
        clipped_next = (used4_reg != '0) && (|clip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid && (action != ACT_LOAD);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            used1_reg    <= used_next;
            vec1_reg     <= {comp_z, comp_y, comp_x};
            pos1_reg     <= (action == ACT_POS);
            w1_reg       <= w1_next;
            ok1_reg      <= ok_next;
            used2_reg    <= used1_reg;
            vec2_reg     <= vec1_reg;
            used3_reg    <= used2_reg;
            vec3_reg     <= vec2_reg;
            used4_reg    <= used3_reg;
            vec4_reg     <= vec3_reg;
            res_reg      <= res_next;
            used_out_reg <= used4_reg;
            skipped_reg  <= (used4_reg == '0);
            clipped_reg  <= clipped_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = res_reg[0];
    assign out_y      = res_reg[1];
    assign out_z      = res_reg[2];
    assign bones_used = used_out_reg;
    assign skipped    = skipped_reg;
    assign clipped    = clipped_reg;

`ifndef SYNTHESIS
    a_skip_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && skipped |-> (bones_used == 3'd0) && !clipped)
        else $error("skipped result with influences or clipping");

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !skipped |-> (bones_used != 3'd0) && (bones_used <= 3'(MAX_INFLUENCES)))
        else $error("bones_used out of range");

    a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v4_reg |=> out_valid)
        else $error("result lost between last stage and output");
`endif

endmodule

### design/lbvs_ram.sv
// Generic single write port RAM with one registered read port.
module lbvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/lbvs_palette.sv
// Bone matrix palette, banked by influence and matrix cell.
module lbvs_palette #(
    parameter int BONE_COUNT     = 256,
    parameter int MAX_INFLUENCES = 4,
    parameter int AW             = 8
) (
    input  logic                        clk,
    input  lbvs_pkg::pal_wr_t           wr,
    input  logic                        re,
    input  logic [MAX_INFLUENCES-1:0][AW-1:0] raddr,
    output logic [MAX_INFLUENCES-1:0][lbvs_pkg::CELLS-1:0][lbvs_pkg::WORD_W-1:0] rdata
);
    import lbvs_pkg::*;

    // Each influence has its own copy of every cell so all bones read at once.
    for (genvar k = 0; k < MAX_INFLUENCES; k++)
    begin : g_infl
        for (genvar c = 0; c < CELLS; c++)
        begin : g_cell
            lbvs_ram #(
                .WIDTH(WORD_W),
                .DEPTH(BONE_COUNT),
                .AW   (AW)
            ) u_ram (
                .clk  (clk),
                .we   (wr.en && (wr.cell_idx == CELL_W'(c))),
                .waddr(wr.slot[AW-1:0]),
                .wdata(wr.word),
                .re   (re),
                .raddr(raddr[k]),
                .rdata(rdata[k][c])
            );
        end
    end

endmodule

### design/lbvs_lane.sv
// One influence lane: matrix products, row sums and weight scaling.
module lbvs_lane (
    input  logic                                              clk,
    input  logic                                              en,
    input  logic                                              is_pos,
    input  logic                                              bone_ok,
    input  logic [lbvs_pkg::WEIGHT_W-1:0]                     weight,
    input  logic [2:0][lbvs_pkg::WORD_W-1:0]                  vec,
    input  logic [lbvs_pkg::CELLS-1:0][lbvs_pkg::WORD_W-1:0]  mat,
    output logic [2:0][lbvs_pkg::CONTRIB_W-1:0]               contrib
);
    import lbvs_pkg::*;

    logic [2:0][2:0][PROD_W-1:0]      prod_reg, prod_next;
    logic [2:0][WORD_W-1:0]           trans_reg, trans_next;
    logic [WEIGHT_W-1:0]              w2_reg, w3_reg;
    logic [2:0][ROW_W-1:0]            row_reg, row_next;
    logic [2:0][CONTRIB_W-1:0]        contrib_reg, contrib_next;
    logic [2:0][2:0][2*WORD_W-1:0]    full;
    logic [2:0][ROW_W+WEIGHT_W:0]     scaled;

    // An out-of-range bone acts as an all-zero matrix.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                full[r][c] = $signed(bone_ok ? mat[r*4+c] : '0) * $signed(vec[c]);
                prod_next[r][c] = full[r][c][2*WORD_W-1:16];
            end
            trans_next[r] = (bone_ok && is_pos) ? mat[r*4+3] : '0;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_next[r] = ROW_W'($signed(prod_reg[r][0])) + ROW_W'($signed(prod_reg[r][1]))
                        + ROW_W'($signed(prod_reg[r][2])) + ROW_W'($signed(trans_reg[r]));
            scaled[r] = $signed(row_reg[r]) * $signed({1'b0, w3_reg});
            contrib_next[r] = scaled[r][ROW_W+WEIGHT_W:14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod_next;
            trans_reg   <= trans_next;
            w2_reg      <= weight;
            row_reg     <= row_next;
            w3_reg      <= w2_reg;
            contrib_reg <= contrib_next;
        end
    end

    assign contrib = contrib_reg;

endmodule

### tb/testbench.sv
// Self-checking testbench for the linear blend vertex skinning core.
`timescale 1ns / 100ps

module testbench;
    import lbvs_pkg::*;

    // One request on the input channel.
    typedef struct {
        action_t            act;
        logic signed [31:0] vx, vy, vz;
        logic [31:0]        bones;
        logic [59:0]        weights;
        logic [7:0]         slot;
        logic [3:0]         cell_idx;
        logic signed [31:0] word;
    } request_t;

    // One skinned vertex on the output channel.
    typedef struct {
        logic signed [31:0] x, y, z;
        logic [2:0]         used;
        logic               skip;
        logic               clip;
    } vertex_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic signed [31:0] comp_x, comp_y, comp_z;
    logic [31:0]        bone_list;
    logic [59:0]        weight_list;
    logic [7:0]         matrix_slot;
    logic [3:0]         matrix_cell;
    logic signed [31:0] matrix_word;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_x, out_y, out_z;
    logic [2:0]         bones_used;
    logic               skipped;
    logic               clipped;

    linear_blend_vertex_skinning_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
        .bone_list(bone_list), .weight_list(weight_list),
        .matrix_slot(matrix_slot), .matrix_cell(matrix_cell),
        .matrix_word(matrix_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .bones_used(bones_used), .skipped(skipped), .clipped(clipped)
    );

    // Requests waiting to be driven, and skinned vertices still owed by the core.
    request_t pending_reqs[$];
    vertex_t  owed_vertices[$];

    // Our own copy of the bone palette, and which bones are fully loaded so
    // that the stimulus never reads an unloaded word.
    logic signed [31:0] palette_copy[256][12];
    bit                 bone_ready[256];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  mismatches;
    int  vertices_seen;
    int  loads_sent;
    int  skins_sent;
    bit  req_taken;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Floor division by a power of two; >>> on a signed value rounds to
    // minus infinity, which is exactly what the core does.
    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    // Blend one vertex over its bone influences, as the core should.
    function automatic vertex_t blend_vertex(request_t r);
        vertex_t        v;
        longint         vec[3];
        longint         acc[3];
        longint         row;
        longint         w;
        int             bone;
        int             used;
        logic           clip;
        vec[0] = r.vx;
        vec[1] = r.vy;
        vec[2] = r.vz;
        acc = '{0, 0, 0};
        used = 0;
        clip = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            w = r.weights[15*k +: 15];
            bone = r.bones[8*k +: 8];
            if (w == 0)
                break;
            for (int rr = 0; rr < 3; rr++)
            begin
                row = 0;
                for (int c = 0; c < 3; c++)
                    row += floor_shr(longint'(palette_copy[bone][rr*4+c]) * vec[c], 16);
                if (r.act == ACT_POS)
                    row += longint'(palette_copy[bone][rr*4+3]);
                acc[rr] += floor_shr(row * w, 14);
            end
            used++;
        end
        if (used == 0)
        begin
            v.x = r.vx;
            v.y = r.vy;
            v.z = r.vz;
            v.used = 3'd0;
            v.skip = 1'b1;
            v.clip = 1'b0;
            return v;
        end
        for (int rr = 0; rr < 3; rr++)
        begin
            if (acc[rr] > 64'sd2147483647)
            begin
                acc[rr] = 64'sd2147483647;
                clip = 1'b1;
            end
            else if (acc[rr] < -64'sd2147483648)
            begin
                acc[rr] = -64'sd2147483648;
                clip = 1'b1;
            end
        end
        v.x = acc[0][31:0];
        v.y = acc[1][31:0];
        v.z = acc[2][31:0];
        v.used = used[2:0];
        v.skip = 1'b0;
        v.clip = clip;
        return v;
    endfunction

    // Queue a matrix word load. The palette copy is updated at acceptance,
    // so that skin requests see loads in the order the core does.
    task automatic queue_load(int slot, int cell_idx, logic [31:0] word);
        request_t r;
        r.act = ACT_LOAD;
        r.vx = $urandom;
        r.vy = $urandom;
        r.vz = $urandom;
        r.bones = $urandom;
        r.weights = 60'({$urandom, $urandom});
        r.slot = 8'(slot);
        r.cell_idx = 4'(cell_idx);
        r.word = word;
        pending_reqs.push_back(r);
    endtask

    // Load all twelve words of a bone. The style selects the matrix: identity,
    // small rotation-like values, or full-range values that provoke clipping.
    task automatic queue_bone(int slot, int style);
        logic [31:0] w;
        for (int c = 0; c < 12; c++)
        begin
            case (style)
                0: w = (c % 5 == 0) ? 32'h0001_0000 : 32'h0;          // identity
                1: w = $urandom_range(0, 32'h0003_FFFF) - 32'h0001_FFFF; // modest
                default: w = $urandom;                                // full range
            endcase
            queue_load(slot, c, w);
        end
        bone_ready[slot] = 1'b1;
    endtask

    // Pick a bone whose matrix is fully loaded.
    function automatic int ready_bone();
        int b;
        do
            b = $urandom_range(0, 255);
        while (!bone_ready[b]);
        return b;
    endfunction

    task automatic queue_skin(action_t act, logic [31:0] vx, logic [31:0] vy,
                              logic [31:0] vz, logic [31:0] bones, logic [59:0] weights);
        request_t r;
        r.act = act;
        r.vx = vx;
        r.vy = vy;
        r.vz = vz;
        r.bones = bones;
        r.weights = weights;
        r.slot = 8'($urandom);
        r.cell_idx = 4'($urandom);
        r.word = $urandom;
        pending_reqs.push_back(r);
    endtask

    // A skin request with random content that reads only loaded bones. Trailing
    // influences after the first zero weight carry any bone number.
    task automatic queue_random_skin();
        logic [31:0] bones;
        logic [59:0] weights;
        int          n;
        action_t     act;
        logic [31:0] v[3];
        n = $urandom_range(0, 4);
        bones = $urandom;
        weights = 60'({$urandom, $urandom});
        for (int k = 0; k < 4; k++)
        begin
            if (k < n)
            begin
                bones[8*k +: 8] = 8'(ready_bone());
                if (weights[15*k +: 15] == 0)
                    weights[15*k +: 15] = 15'h4000;
                case ($urandom_range(0, 3))
                    0: weights[15*k +: 15] = 15'h7FFF;
                    1: weights[15*k +: 15] = 15'($urandom_range(1, 15'h4000));
                    default: ;
                endcase
            end
            else if (k == n)
                weights[15*k +: 15] = '0;
        end
        act = action_t'($urandom_range(1, 3));
        for (int i = 0; i < 3; i++)
            case ($urandom_range(0, 5))
                0: v[i] = 32'h7FFF_FFFF;
                1: v[i] = 32'h8000_0000;
                2: v[i] = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                default: v[i] = $urandom;
            endcase
        queue_skin(act, v[0], v[1], v[2], bones, weights);
    endtask

    // Driver: presents the head of the queue at falling edges and holds it
    // until the core takes it. Valid is decided without looking at stall.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    action      <= pending_reqs[0].act;
                    comp_x      <= pending_reqs[0].vx;
                    comp_y      <= pending_reqs[0].vy;
                    comp_z      <= pending_reqs[0].vz;
                    bone_list   <= pending_reqs[0].bones;
                    weight_list <= pending_reqs[0].weights;
                    matrix_slot <= pending_reqs[0].slot;
                    matrix_cell <= pending_reqs[0].cell_idx;
                    matrix_word <= pending_reqs[0].word;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Acceptance on the input side: retire the driven request, then update the
    // palette copy or record the expected vertex at the same rising edge the
    // core takes the request.
    always @(posedge clk)
    begin
        req_taken = rst_n && in_valid && !in_stall;
        if (req_taken)
        begin
            request_t r;
            r.act = action_t'(action);
            r.vx = comp_x;
            r.vy = comp_y;
            r.vz = comp_z;
            r.bones = bone_list;
            r.weights = weight_list;
            r.slot = matrix_slot;
            r.cell_idx = matrix_cell;
            r.word = matrix_word;
            void'(pending_reqs.pop_front());
            if (r.act == ACT_LOAD)
            begin
                loads_sent++;
                if (r.cell_idx < 12)
                    palette_copy[r.slot][r.cell_idx] = r.word;
            end
            else
            begin
                skins_sent++;
                owed_vertices.push_back(blend_vertex(r));
            end
        end
    end

    // Monitor: compares every accepted vertex with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            vertices_seen++;
            if (owed_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex out %h %h %h", out_x, out_y, out_z);
            end
            else
            begin
                vertex_t e;
                e = owed_vertices.pop_front();
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
                    bones_used !== e.used || skipped !== e.skip || clipped !== e.clip)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"vertex mismatch: expected %h %h %h used %0d skip %b",
                                  " clip %b, got %h %h %h used %0d skip %b clip %b"},
                                 e.x, e.y, e.z, e.used, e.skip, e.clip,
                                 out_x, out_y, out_z, bones_used, skipped, clipped);
                end
            end
        end
    end

    // Run one phase of random requests under the given idle settings.
    task automatic run_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // Odd loads: out-of-range cells are dropped; in-range cells
                // rewrite a bone with new content.
                if ($urandom_range(0, 1))
                    queue_load($urandom_range(0, 255), $urandom_range(12, 15), $urandom);
                else
                    queue_bone($urandom_range(0, 255), $urandom_range(0, 2));
            end
            else
                queue_random_skin();
        end
        while (pending_reqs.size() > 0 || owed_vertices.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = '0;
        comp_x = '0;
        comp_y = '0;
        comp_z = '0;
        bone_list = '0;
        weight_list = '0;
        matrix_slot = '0;
        matrix_cell = '0;
        matrix_word = '0;
        mismatches = 0;
        vertices_seen = 0;
        loads_sent = 0;
        skins_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int b = 0; b < 256; b++)
        begin
            bone_ready[b] = 1'b0;
            for (int c = 0; c < 12; c++)
                palette_copy[b][c] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: an identity bone in slot 0, a full-range bone in slot
        // 255 and a modest bone in slot 7, then the special cases.
        queue_bone(0, 0);
        queue_bone(255, 2);
        queue_bone(7, 1);
        // Identity with full weight on a position and on a normal.
        queue_skin(ACT_POS, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                   32'h0, {45'h0, 15'h4000});
        queue_skin(ACT_NORMAL, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
                   32'h0, {45'h0, 15'h4000});
        // First weight zero: vector passes through, skipped.
        queue_skin(ACT_TANGENT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
                   32'hFFFF_FFFF, {45'h1FFF_FFFF_FFFF, 15'h0});
        // Four influences at maximum weight, mixed bones and extreme vectors: clips.
        queue_skin(ACT_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hFF00_FF00, {4{15'h7FFF}});
        queue_skin(ACT_TANGENT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h07FF_00FF, {4{15'h7FFF}});
        // Zero weight in the middle ends the list early.
        queue_skin(ACT_NORMAL, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000,
                   32'hABCD_0700, {15'h7FFF, 15'h1, 15'h0, 15'h2000});
        // Load with cell beyond eleven is ignored.
        queue_load(0, 12, 32'hDEAD_BEEF);
        queue_load(0, 15, 32'hFFFF_FFFF);
        queue_skin(ACT_POS, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000,
                   32'h0, {45'h0, 15'h4000});
        while (pending_reqs.size() > 0 || owed_vertices.size() > 0)
            @(posedge clk);

        // A handful of bones in every style before random traffic.
        for (int i = 0; i < 12; i++)
            queue_bone($urandom_range(1, 254), i % 3);

        run_phase(0, 0, 150);
        run_phase(48, 0, 150);
        run_phase(0, 48, 150);
        run_phase(18, 18, 150);

        // Let the pipeline drain, then report.
        repeat (20) @(posedge clk);
        $display("Covered %0d matrix loads and %0d skin requests; %0d vertices checked.",
                 loads_sent, skins_sent, vertices_seen);
        $display("Phases ran without idling, with sender gaps, with receiver stalls and both.");
        if (mismatches == 0 && owed_vertices.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
